@@ src/ssp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ssp_pkg;

  // Page and record geometry.
  localparam int unsigned SAMPLES_PER_PAGE = 12;
  localparam int unsigned SLOT_W           = 4;
  localparam int unsigned HEADER_BYTES     = 16;
  localparam int unsigned RECORD_BYTES     = 20;
  localparam int unsigned FRAME_BYTES      = HEADER_BYTES + RECORD_BYTES;
  localparam int unsigned BYTE_IDX_W       = $clog2(FRAME_BYTES);
  localparam int unsigned NUM_AXES         = 6;
  localparam int unsigned AXIS_IDX_W       = $clog2(NUM_AXES);

  // Queue between the classifier and the serializer.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Configuration port.
  localparam int unsigned APB_ADDR_W   = 3;
  localparam int unsigned APB_DATA_W   = 32;
  localparam logic [7:0]  MIN_RATE_RST = 8'd30;
  localparam logic [7:0]  MAX_RATE_RST = 8'd220;

  typedef enum logic [APB_ADDR_W-3:0] {
    REG_MIN_RATE = 1'b0,
    REG_MAX_RATE = 1'b1
  } ssp_reg_e;

  // Event codes carried in the kind field.
  typedef enum logic [1:0] {
    KIND_BEAT   = 2'd0,
    KIND_TEMP   = 2'd1,
    KIND_MOTION = 2'd2
  } ssp_kind_e;

  // Heart rate arithmetic: rate = 60000 / interval.
  localparam logic [39:0] BEAT_NUM     = 40'd60000;
  localparam logic [40:0] BEAT_NUM2    = 41'd120000;
  localparam int unsigned RATE_BITS    = 8;

  // Fahrenheit times 100 = (9 * c + 16000) / 5, quotient by reciprocal.
  localparam logic signed [19:0] TEMP_OFFSET = 20'sd16000;
  localparam logic [15:0]        RECIP_5     = 16'd52429;
  localparam int unsigned        RECIP_SHIFT = 18;

  // Motion scaling: value * MUL / 2^SHIFT.
  localparam logic [9:0]  ACCEL_MUL   = 10'd1000;
  localparam int unsigned ACCEL_SHIFT = 10;
  localparam logic [9:0]  GYRO_MUL    = 10'd10;
  localparam int unsigned GYRO_SHIFT  = 6;

  // Header magic "HPK1".
  localparam logic [7:0] MAGIC [4] = '{8'h48, 8'h50, 8'h4B, 8'h31};

  // One sample record handed from the front to the back.
  typedef struct packed {
    logic                       hdr;
    logic                       last;
    logic [7:0]                 seq;
    logic [7:0]                 rate;
    logic [15:0]                temp;
    logic [NUM_AXES-1:0][15:0]  axis;
    logic [31:0]                time_ms;
  } ssp_job_t;

endpackage

`default_nettype wire

@@ src/ssp_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface ssp_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [31:0]        time_ms;
  logic signed [14:0] temp_centi_c;
  logic               temp_valid;
  logic signed [19:0] accel_x;
  logic signed [19:0] accel_y;
  logic signed [19:0] accel_z;
  logic signed [23:0] gyro_x;
  logic signed [23:0] gyro_y;
  logic signed [23:0] gyro_z;

  modport source (
    output valid, kind, time_ms, temp_centi_c, temp_valid,
    output accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
    input  ready
  );

  modport sink (
    input  valid, kind, time_ms, temp_centi_c, temp_valid,
    input  accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
    output ready
  );
endinterface

`default_nettype wire

@@ src/ssp_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface ssp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] page_byte;
  logic       end_of_page;
  logic       end_of_run;

  modport source (
    output valid, page_byte, end_of_page, end_of_run,
    input  ready
  );

  modport sink (
    input  valid, page_byte, end_of_page, end_of_run,
    output ready
  );
endinterface

`default_nettype wire

@@ src/ssp_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ssp_fifo #(
  parameter int unsigned DEPTH = ssp_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ssp_pkg::ssp_job_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output ssp_pkg::ssp_job_t pop_data_o,
  output logic             empty_o
);
  import ssp_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ssp_job_t           mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   count_q;
  logic               do_push, do_pop;

  assign full_o     = (count_q == CNT_W'(DEPTH));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

@@ src/ssp_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ssp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  ssp_in_if.sink            in_i,
  input  logic [7:0]        min_rate_i,
  input  logic [7:0]        max_rate_i,
  output ssp_pkg::ssp_job_t job_o,
  output logic              job_valid_o,
  input  logic              job_ready_i
);
  import ssp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BEAT_MIN,
    ST_BEAT_MAX,
    ST_BEAT_DIV,
    ST_TEMP,
    ST_SCALE,
    ST_PUSH
  } state_e;

  state_e                 state_q;
  logic [31:0]            last_beat_q;
  logic [7:0]             rate_q;
  logic [15:0]            temp_f_q;
  logic [7:0]             seq_q;
  logic [SLOT_W-1:0]      slot_q;

  logic [31:0]            interval_q;
  logic [40:0]            rem_q, dsh_q;
  logic [RATE_BITS-1:0]   quo_q;
  logic [2:0]             bit_q;
  logic signed [14:0]     temp_in_q;
  logic signed [23:0]     src_q [NUM_AXES];
  logic [15:0]            axis_q [NUM_AXES];
  logic [AXIS_IDX_W-1:0]  cnt_q;
  logic [31:0]            time_q;

  // Beat interval measured against the previous beat; no earlier beat reads as zero.
  logic [31:0] beat_delta;
  assign beat_delta = (last_beat_q == '0) ? '0 : in_i.time_ms - last_beat_q;

  // Rate window checks, one per state: the minimum first, then the maximum.
  logic [39:0] min_prod, max_prod;
  assign min_prod = 40'(min_rate_i) * 40'(interval_q);
  assign max_prod = 40'(max_rate_i) * 40'(interval_q);

  // One restoring division step of (120000 + d) / (2 d).
  logic        div_ge;
  logic [40:0] rem_next;
  assign div_ge   = (rem_q >= dsh_q);
  assign rem_next = div_ge ? rem_q - dsh_q : rem_q;

  // Fahrenheit conversion; the result always fits in 16 signed bits.
  logic signed [19:0] temp_c_ext, temp_x;
  logic [17:0]        temp_mag;
  logic [33:0]        temp_prod;
  logic [15:0]        temp_q16, temp_result;
  assign temp_c_ext  = 20'(temp_in_q);
  assign temp_x      = (temp_c_ext <<< 3) + temp_c_ext + TEMP_OFFSET;
  assign temp_mag    = temp_x[19] ? 18'(-temp_x) : 18'(temp_x);
  assign temp_prod   = 34'(temp_mag + 18'd2) * 34'(RECIP_5);
  assign temp_q16    = temp_prod[RECIP_SHIFT +: 16];
  assign temp_result = temp_x[19] ? 16'(16'd0 - temp_q16) : temp_q16;

  // Shared scaling unit, one axis per cycle: accelerometer first, then gyro.
  logic               is_accel, src_neg;
  logic signed [23:0] src_val;
  logic [23:0]        src_mag;
  logic [33:0]        scale_prod, scale_sum, scale_q;
  logic [15:0]        scale_result;
  assign is_accel   = (cnt_q < AXIS_IDX_W'(3));
  assign src_val    = src_q[cnt_q];
  assign src_neg    = src_val[23];
  assign src_mag    = src_neg ? 24'(-src_val) : 24'(src_val);
  assign scale_prod = 34'(src_mag) * 34'(is_accel ? ACCEL_MUL : GYRO_MUL);
  assign scale_sum  = scale_prod + (is_accel ? 34'(1) << (ACCEL_SHIFT - 1)
                                             : 34'(1) << (GYRO_SHIFT - 1));
  assign scale_q    = is_accel ? scale_sum >> ACCEL_SHIFT : scale_sum >> GYRO_SHIFT;

  always_comb begin
    if (src_neg) begin
      scale_result = (scale_q > 34'd32768) ? 16'h8000 : 16'(16'd0 - scale_q[15:0]);
    end else begin
      scale_result = (scale_q > 34'd32767) ? 16'h7FFF : scale_q[15:0];
    end
  end

  // Record handed to the queue.
  always_comb begin
    job_o.hdr     = (slot_q == '0);
    job_o.last    = ((5'(slot_q) + 5'd1) >= 5'(SAMPLES_PER_PAGE));
    job_o.seq     = seq_q;
    job_o.rate    = rate_q;
    job_o.temp    = temp_f_q;
    for (int i = 0; i < NUM_AXES; i++) begin
      job_o.axis[i] = axis_q[i];
    end
    job_o.time_ms = time_q;
  end

  assign job_valid_o = (state_q == ST_PUSH);
  assign in_i.ready  = (state_q == ST_IDLE);

  // Sequencer and sensor state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      last_beat_q <= '0;
      rate_q      <= '0;
      temp_f_q    <= '0;
      seq_q       <= '0;
      slot_q      <= '0;
      interval_q  <= '0;
      rem_q       <= '0;
      dsh_q       <= '0;
      quo_q       <= '0;
      bit_q       <= '0;
      temp_in_q   <= '0;
      cnt_q       <= '0;
      time_q      <= '0;
      for (int i = 0; i < NUM_AXES; i++) begin
        src_q[i]  <= '0;
        axis_q[i] <= '0;
      end
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            unique case (in_i.kind)
              KIND_BEAT: begin
                last_beat_q <= in_i.time_ms;
                interval_q  <= beat_delta;
                if (beat_delta != '0) begin
                  state_q <= ST_BEAT_MIN;
                end
              end
              KIND_TEMP: begin
                temp_in_q <= in_i.temp_centi_c;
                if (in_i.temp_valid) begin
                  state_q <= ST_TEMP;
                end
              end
              KIND_MOTION: begin
                src_q[0] <= 24'(in_i.accel_x);
                src_q[1] <= 24'(in_i.accel_y);
                src_q[2] <= 24'(in_i.accel_z);
                src_q[3] <= in_i.gyro_x;
                src_q[4] <= in_i.gyro_y;
                src_q[5] <= in_i.gyro_z;
                time_q   <= in_i.time_ms;
                cnt_q    <= '0;
                state_q  <= ST_SCALE;
              end
              default: begin
                state_q <= ST_IDLE;
              end
            endcase
          end
        end
        ST_BEAT_MIN: begin
          state_q <= (min_prod <= BEAT_NUM) ? ST_BEAT_MAX : ST_IDLE;
        end
        ST_BEAT_MAX: begin
          rem_q   <= BEAT_NUM2 + 41'(interval_q);
          dsh_q   <= 41'({interval_q, 1'b0}) << (RATE_BITS - 1);
          bit_q   <= 3'(RATE_BITS - 1);
          state_q <= (max_prod >= BEAT_NUM) ? ST_BEAT_DIV : ST_IDLE;
        end
        ST_BEAT_DIV: begin
          rem_q <= rem_next;
          dsh_q <= dsh_q >> 1;
          quo_q <= {quo_q[RATE_BITS-2:0], div_ge};
          bit_q <= bit_q - 1'b1;
          if (bit_q == '0) begin
            rate_q  <= {quo_q[RATE_BITS-2:0], div_ge};
            state_q <= ST_IDLE;
          end
        end
        ST_TEMP: begin
          temp_f_q <= temp_result;
          state_q  <= ST_IDLE;
        end
        ST_SCALE: begin
          axis_q[cnt_q] <= scale_result;
          cnt_q         <= cnt_q + 1'b1;
          if (cnt_q == AXIS_IDX_W'(NUM_AXES - 1)) begin
            state_q <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (job_ready_i) begin
            if (job_o.last) begin
              slot_q <= '0;
              seq_q  <= seq_q + 1'b1;
            end else begin
              slot_q <= slot_q + 1'b1;
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/ssp_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ssp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ssp_pkg::ssp_job_t job_i,
  input  logic              job_valid_i,
  output logic              job_pop_o,
  ssp_out_if.source         out_o
);
  import ssp_pkg::*;

  logic [BYTE_IDX_W-1:0] idx_q, idx_eff, rec_idx;
  logic                  out_valid_q, out_eop_q, out_eor_q;
  logic [7:0]            out_byte_q, byte_sel;
  logic                  load, last_byte;
  logic [15:0]           word_sel;
  logic [2:0]            word_idx;

  // A record without header starts right after the header bytes.
  assign idx_eff   = (idx_q == '0 && !job_i.hdr) ? BYTE_IDX_W'(HEADER_BYTES) : idx_q;
  assign rec_idx   = idx_eff - BYTE_IDX_W'(HEADER_BYTES);
  assign last_byte = (idx_eff == BYTE_IDX_W'(FRAME_BYTES - 1));
  assign load      = job_valid_i && (!out_valid_q || out_o.ready);
  assign job_pop_o = load && last_byte;
  assign word_idx  = rec_idx[3:1];

  // Little-endian 16-bit words of the record.
  always_comb begin
    case (word_idx)
      3'd0:    word_sel = {8'h00, job_i.rate};
      3'd1:    word_sel = job_i.temp;
      default: word_sel = job_i.axis[AXIS_IDX_W'(word_idx - 3'd2)];
    endcase
  end

  // Byte of the current position: header, record words, then timestamp.
  always_comb begin
    if (idx_eff < BYTE_IDX_W'(HEADER_BYTES)) begin
      if (idx_eff < BYTE_IDX_W'(4)) begin
        byte_sel = MAGIC[idx_eff[1:0]];
      end else if (idx_eff == BYTE_IDX_W'(4)) begin
        byte_sel = job_i.seq;
      end else begin
        byte_sel = 8'h00;
      end
    end else if (rec_idx < BYTE_IDX_W'(16)) begin
      byte_sel = rec_idx[0] ? word_sel[15:8] : word_sel[7:0];
    end else begin
      byte_sel = job_i.time_ms[8*rec_idx[1:0] +: 8];
    end
  end

  // Position counter and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      out_eop_q   <= 1'b0;
      out_eor_q   <= 1'b0;
    end else begin
      if (load) begin
        idx_q       <= last_byte ? '0 : idx_eff + 1'b1;
        out_valid_q <= 1'b1;
        out_byte_q  <= byte_sel;
        out_eop_q   <= last_byte && job_i.last;
        out_eor_q   <= last_byte;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.page_byte   = out_byte_q;
  assign out_o.end_of_page = out_eop_q;
  assign out_o.end_of_run  = out_eor_q;

endmodule

`default_nettype wire

@@ src/sensor_sample_page_framer_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Sensor sample page framer. Beat events (kind 0) update the stored heart rate,
// temperature events (kind 1) the stored Fahrenheit value, and motion samples
// (kind 2) are framed into a byte stream: a 16-byte header "HPK1", sequence and
// zeros at each page start, then a 20-byte little-endian record. One byte
// transaction leaves per cycle while the sink is ready, so a sample yields 36
// bytes with a header and 20 without; the output serializer sets the rate. An
// ignored item leaves the front ready. It is busy converting a temperature,
// running a beat through two window checks and an 8-step divider, or a motion
// sample through six shared scaling steps and a queue push, and stalls only on
// a full sample queue. The user must write min_rate_bpm (address 0) and
// max_rate_bpm (address 4) over APB only while the block is idle; it does not enforce this.
module sensor_sample_page_framer_core #(
  parameter int unsigned QUEUE_DEPTH = ssp_pkg::QUEUE_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  ssp_in_if.sink                            in_i,
  ssp_out_if.source                         out_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ssp_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [ssp_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [ssp_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import ssp_pkg::*;

  logic [7:0] min_rate_q, max_rate_q;
  ssp_reg_e   reg_sel;
  logic       cfg_write;

  ssp_job_t   front_job, queue_head;
  logic       front_valid, queue_full, queue_empty, back_pop;

  // Configuration registers.
  assign reg_sel   = ssp_reg_e'(paddr[APB_ADDR_W-1:2]);
  assign cfg_write = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_rate_q <= MIN_RATE_RST;
      max_rate_q <= MAX_RATE_RST;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_MIN_RATE: min_rate_q <= pwdata[7:0];
        REG_MAX_RATE: max_rate_q <= pwdata[7:0];
        default:      min_rate_q <= min_rate_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_MIN_RATE: prdata = APB_DATA_W'(min_rate_q);
      REG_MAX_RATE: prdata = APB_DATA_W'(max_rate_q);
      default:      prdata = '0;
    endcase
  end

  // Event classification and sample scaling.
  ssp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .min_rate_i  (min_rate_q),
    .max_rate_i  (max_rate_q),
    .job_o       (front_job),
    .job_valid_o (front_valid),
    .job_ready_i (!queue_full)
  );

  // Sample queue decoupling the two halves.
  ssp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (front_valid),
    .push_data_i (front_job),
    .full_o      (queue_full),
    .pop_i       (back_pop),
    .pop_data_o  (queue_head),
    .empty_o     (queue_empty)
  );

  // Byte serializer.
  ssp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (queue_head),
    .job_valid_i (!queue_empty),
    .job_pop_o   (back_pop),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

@@ src/ssp_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ssp_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic [1:0]                     in_kind,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [7:0]                     out_byte,
  input logic                           out_eop,
  input logic                           out_eor,
  input logic                           psel,
  input logic                           penable,
  input logic                           pwrite,
  input logic [ssp_pkg::APB_ADDR_W-1:0] paddr,
  input logic [ssp_pkg::APB_DATA_W-1:0] pwdata,
  input logic [ssp_pkg::APB_DATA_W-1:0] prdata
);
  import ssp_pkg::*;

  // A stalled byte transaction holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_eop)
                                && $stable(out_eor))
    else $error("output byte changed while stalled");

  // A page only ends on the last byte of a sample.
  a_eop_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_eop |-> out_eor)
    else $error("end of page outside the end of a run");

  // A motion sample keeps the front busy while it is scaled.
  a_motion_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && in_kind == KIND_MOTION |=> !in_ready)
    else $error("front accepted an item while scaling a sample");

  // A written rate register reads back its new value.
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(psel && penable && pwrite) && ($past(paddr[APB_ADDR_W-1:2]) == paddr[APB_ADDR_W-1:2])
    |-> prdata[7:0] == $past(pwdata[7:0]))
    else $error("configuration register read back mismatch");

endmodule

bind sensor_sample_page_framer_core ssp_checker u_ssp_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .in_kind   (in_i.kind),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_byte  (out_o.page_byte),
  .out_eop   (out_o.end_of_page),
  .out_eor   (out_o.end_of_run),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata)
);

`default_nettype wire
